FILE: rtl/rwcd_pkg.sv
// rwcd_pkg: shared types, sizes and the arctangent table of the ray range finder
// no dependencies; imported by ray_wall_circle_distance and its testbench

package rwcd_pkg;

  localparam int MAX_WALLS    = 64;
  localparam int MAX_CIRCLES  = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int ANGLE_SH     = 32 - ANGLE_BITS;
  localparam int WALL_AW      = $clog2(MAX_WALLS);
  localparam int CIRC_AW      = $clog2(MAX_CIRCLES);
  localparam int WALL_CW      = $clog2(MAX_WALLS + 1);
  localparam int CIRC_CW      = $clog2(MAX_CIRCLES + 1);
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [39:0] CORDIC_GAIN = 40'sd652032874;

  // request kinds
  localparam logic [1:0] REQ_WALL   = 2'd0;
  localparam logic [1:0] REQ_CIRCLE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic REG_WALL_COUNT   = 1'b0;
  localparam logic REG_CIRCLE_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [5:0]            slot;
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    qx;
    logic signed [31:0]    qy;
    logic [ANGLE_BITS-1:0] heading;
  } in_req_t;

  typedef struct packed {
    logic [31:0]           range;
    logic [ANGLE_BITS-1:0] normal_angle;
    logic                  hit;
  } out_res_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ray_wall_circle_distance.sv
// ray_wall_circle_distance: ray cast over wall segment and circle tables
// one sequencer drives a shared multiplier, adder and shifter; uses rwcd_pkg
// write requests take effect at the accept edge and give no result.
// a query first runs the heading vector cordic, then per wall the determinant tests
// and, when they pass, the bit-serial divider; per circle the products and, unless
// the discriminant is negative, the root; and the angle cordic for each hit
// nearer than the best so far.
// one request in flight at a time; busy stays high until the one-cycle result strobe.
// reset (synchronous, active low) idles the sequencer and clears both counts.
module ray_wall_circle_distance
  import rwcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_data,
  output logic     out_valid,
  output out_res_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int MW        = 36;   // multiplier operand width
  localparam int PW        = 72;   // product and accumulator width
  localparam int DIV_STEPS = 97;   // quotient bits of (k3 << 30) / k4

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIR    = 5'd1;
  localparam logic [4:0] S_DIRFIN = 5'd2;
  localparam logic [4:0] S_WRD    = 5'd3;
  localparam logic [4:0] S_WDIFF  = 5'd4;
  localparam logic [4:0] S_WMUL   = 5'd5;
  localparam logic [4:0] S_WTEST  = 5'd6;
  localparam logic [4:0] S_WDIV   = 5'd7;
  localparam logic [4:0] S_WCMP   = 5'd8;
  localparam logic [4:0] S_CRD    = 5'd9;
  localparam logic [4:0] S_CDIFF  = 5'd10;
  localparam logic [4:0] S_CMUL   = 5'd11;
  localparam logic [4:0] S_CTEST  = 5'd12;
  localparam logic [4:0] S_CSQRT  = 5'd13;
  localparam logic [4:0] S_CT     = 5'd14;
  localparam logic [4:0] S_CVEC   = 5'd15;
  localparam logic [4:0] S_ANORM  = 5'd16;
  localparam logic [4:0] S_ADN    = 5'd17;
  localparam logic [4:0] S_AUP    = 5'd18;
  localparam logic [4:0] S_AROT   = 5'd19;
  localparam logic [4:0] S_AFIN   = 5'd20;
  localparam logic [4:0] S_DONE   = 5'd21;

  // table storage, word layouts {qy, qx, py, px} and {radius, cy, cx}
  logic [127:0] wall_mem [MAX_WALLS];
  logic [95:0]  circ_mem [MAX_CIRCLES];
  logic [127:0] wall_rd_r;
  logic [95:0]  circ_rd_r;

  logic [4:0]           state_r;
  logic [6:0]           wall_count_r;
  logic [5:0]           circle_count_r;
  logic [WALL_CW-1:0]   widx_r;
  logic [CIRC_CW-1:0]   cidx_r;
  logic [6:0]           cnt_r;
  logic [3:0]           mstep_r;

  // query geometry
  logic [31:0]          theta_r;
  logic signed [31:0]   sx_r, sy_r;
  logic signed [33:0]   ex_r, ey_r;

  // shared cordic registers
  logic signed [39:0]   cx_r, cy_r;
  logic [31:0]          cz_r;

  // per-entry operands
  logic signed [32:0]   rax_r, ray_r, rbx_r, rby_r, gx_r, gy_r;
  logic signed [32:0]   wx_r, wy_r;
  logic signed [31:0]   rad_r;

  // multiplier and accumulator
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r, acc_r;
  logic signed [PW-1:0] acc_sum, acc_dif;

  // wall determinants and divider
  logic                 k1n_r, k2n_r;
  logic signed [PW-1:0] k3_r, k4_r;
  logic [DIV_STEPS-1:0] dnum_r;
  logic [PW-1:0]        drem_r;
  logic [63:0]          dq_r;
  logic                 dsat_r;

  // circle terms and square root
  logic signed [35:0]   along_r, across_r;
  logic signed [PW-1:0] disc_r;
  logic [63:0]          sq_n_r;
  logic [33:0]          sq_rem_r;
  logic [31:0]          sq_root_r;
  logic signed [35:0]   t_r;

  // best hits
  logic                 wok_r, cok_r, ret_circ_r;
  logic [63:0]          wd_r, cd_r;
  logic [31:0]          wa_r, ca_r;

  logic                 out_valid_r;
  out_res_t             out_data_r;

  // combinational helpers
  logic                 in_accept, wall_we, circ_we;
  logic                 walls_done, circs_done;
  logic signed [39:0]   xs, ys;
  logic                 rot_pos;
  logic [31:0]          atan_v;
  logic [39:0]          ax_m, ay_m, big_m;
  logic [PW-1:0]        rem_sh;
  logic                 div_take;
  logic [35:0]          sq_r2, sq_trial;
  logic                 sq_take;
  logic signed [37:0]   t_lo, t_hi, t_sel;
  logic                 t_ok;
  logic [63:0]          t_u, wd_cand;
  logic [63:0]          fin_d;
  logic [31:0]          fin_a, norm_tmp;
  logic                 fin_hit;

  assign in_accept = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // slot beyond a table drops the write
  assign wall_we = in_accept && (in_data.req_type == REQ_WALL) && (32'(in_data.slot) < MAX_WALLS);
  assign circ_we = in_accept && (in_data.req_type == REQ_CIRCLE)
                   && (32'(in_data.slot) < MAX_CIRCLES);

  // counts beyond the tables clamp to the table size
  assign walls_done = (32'(widx_r) >= 32'(wall_count_r)) || (32'(widx_r) >= MAX_WALLS);
  assign circs_done = (32'(cidx_r) >= 32'(circle_count_r)) || (32'(cidx_r) >= MAX_CIRCLES);

  // table memories, one write port and one registered read port each
  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[WALL_AW'(in_data.slot)] <= {in_data.qy, in_data.qx, in_data.py, in_data.px};
    end
    wall_rd_r <= wall_mem[widx_r[WALL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (circ_we) begin
      circ_mem[CIRC_AW'(in_data.slot)] <= {in_data.qx, in_data.py, in_data.px};
    end
    circ_rd_r <= circ_mem[cidx_r[CIRC_AW-1:0]];
  end

  // multiplier operand select: one product per cycle, registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_WMUL) begin
      case (mstep_r)
        4'd0: begin mul_a = MW'(rax_r); mul_b = MW'(ey_r);  end
        4'd1: begin mul_a = MW'(ex_r);  mul_b = MW'(ray_r); end
        4'd2: begin mul_a = MW'(ex_r);  mul_b = MW'(rby_r); end
        4'd3: begin mul_a = MW'(rbx_r); mul_b = MW'(ey_r);  end
        4'd4: begin mul_a = MW'(rax_r); mul_b = MW'(gy_r);  end
        4'd5: begin mul_a = MW'(gx_r);  mul_b = MW'(ray_r); end
        4'd6: begin mul_a = MW'(ex_r);  mul_b = MW'(gy_r);  end
        4'd7: begin mul_a = MW'(gx_r);  mul_b = MW'(ey_r);  end
        default: ;
      endcase
    end else if (state_r == S_CMUL) begin
      case (mstep_r)
        4'd0: begin mul_a = MW'(wx_r);  mul_b = MW'(ex_r);     end
        4'd1: begin mul_a = MW'(wy_r);  mul_b = MW'(ey_r);     end
        4'd2: begin mul_a = MW'(wx_r);  mul_b = MW'(ey_r);     end
        4'd3: begin mul_a = MW'(wy_r);  mul_b = MW'(ex_r);     end
        4'd4: begin mul_a = MW'(rad_r); mul_b = MW'(rad_r);    end
        4'd5: begin mul_a = across_r;   mul_b = across_r;      end
        default: ;
      endcase
    end else if (state_r == S_CVEC) begin
      case (mstep_r)
        4'd0: begin mul_a = t_r; mul_b = MW'(ex_r); end
        4'd1: begin mul_a = t_r; mul_b = MW'(ey_r); end
        default: ;
      endcase
    end
  end

  assign acc_sum = acc_r + prod_r;
  assign acc_dif = acc_r - prod_r;

  // cordic step, shared by heading rotation and normal vectoring
  assign xs      = cx_r >>> cnt_r[4:0];
  assign ys      = cy_r >>> cnt_r[4:0];
  assign atan_v  = atan_turn(cnt_r[4:0]);
  assign rot_pos = (state_r == S_DIR) ? !cz_r[31] : cy_r[39];

  // magnitudes for vector scaling
  assign ax_m  = cx_r[39] ? 40'(-cx_r) : 40'(cx_r);
  assign ay_m  = cy_r[39] ? 40'(-cy_r) : 40'(cy_r);
  assign big_m = (ax_m > ay_m) ? ax_m : ay_m;

  // restoring divider step
  assign rem_sh   = {drem_r[PW-2:0], dnum_r[DIV_STEPS-1]};
  assign div_take = (rem_sh >= $unsigned(k4_r));
  assign wd_cand  = dsat_r ? '1 : dq_r;

  // digit-by-digit square root step
  assign sq_r2    = {sq_rem_r, sq_n_r[63:62]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign sq_take  = (sq_r2 >= sq_trial);

  // nearest intersection strictly ahead
  assign t_lo  = 38'(along_r) - 38'($signed({1'b0, sq_root_r}));
  assign t_hi  = 38'(along_r) + 38'($signed({1'b0, sq_root_r}));
  assign t_ok  = (t_lo > 38'sd0) || (t_hi > 38'sd0);
  assign t_sel = (t_lo > 38'sd0) ? t_lo : t_hi;
  assign t_u   = 64'(t_sel);

  // final pick: a wall beats a circle only when strictly nearer
  always_comb begin
    fin_hit = 1'b1;
    fin_d   = wd_r;
    fin_a   = wa_r;
    if (wok_r && (!cok_r || (wd_r < cd_r))) begin
      fin_d = wd_r;
      fin_a = wa_r;
    end else if (cok_r) begin
      fin_d = cd_r;
      fin_a = ca_r;
    end else begin
      fin_hit = 1'b0;
    end
  end

  assign norm_tmp = fin_a - theta_r + (32'd1 << (ANGLE_SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      wall_count_r   <= '0;
      circle_count_r <= '0;
      out_valid_r    <= 1'b0;
      wok_r          <= 1'b0;
      cok_r          <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WALL_COUNT:   wall_count_r   <= cfg_data[6:0];
          REG_CIRCLE_COUNT: circle_count_r <= cfg_data[5:0];
        endcase
      end

      // product register runs every cycle
      prod_r <= mul_a * mul_b;

      unique case (state_r)
        S_IDLE: begin
          if (in_accept && (in_data.req_type == REQ_QUERY)) begin
            theta_r <= {in_data.heading, {ANGLE_SH{1'b0}}};
            sx_r    <= in_data.px;
            sy_r    <= in_data.py;
            cx_r    <= CORDIC_GAIN;
            cy_r    <= '0;
            // first-quadrant part of the turn angle
            cz_r    <= {2'b00, in_data.heading[ANGLE_BITS-3:0], {ANGLE_SH{1'b0}}};
            cnt_r   <= '0;
            state_r <= S_DIR;
          end
        end

        // rotation and vectoring share this step
        S_DIR, S_AROT: begin
          if (rot_pos) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - atan_v;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + atan_v;
          end
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(CORDIC_STEPS - 1)) begin
            state_r <= (state_r == S_DIR) ? S_DIRFIN : S_AFIN;
          end
        end

        // quadrant swap of the unit vector
        S_DIRFIN: begin
          unique case (theta_r[31:30])
            2'd0: begin ex_r <= 34'(cx_r);  ey_r <= 34'(cy_r);  end
            2'd1: begin ex_r <= 34'(-cy_r); ey_r <= 34'(cx_r);  end
            2'd2: begin ex_r <= 34'(-cx_r); ey_r <= 34'(-cy_r); end
            2'd3: begin ex_r <= 34'(cy_r);  ey_r <= 34'(-cx_r); end
          endcase
          widx_r  <= '0;
          wok_r   <= 1'b0;
          cok_r   <= 1'b0;
          state_r <= S_WRD;
        end

        // wall entry read lands in wall_rd_r
        S_WRD: begin
          if (walls_done) begin
            cidx_r  <= '0;
            state_r <= S_CRD;
          end else begin
            state_r <= S_WDIFF;
          end
        end

        S_WDIFF: begin
          rax_r   <= 33'($signed(wall_rd_r[31:0]))   - 33'(sx_r);
          ray_r   <= 33'($signed(wall_rd_r[63:32]))  - 33'(sy_r);
          rbx_r   <= 33'($signed(wall_rd_r[95:64]))  - 33'(sx_r);
          rby_r   <= 33'($signed(wall_rd_r[127:96])) - 33'(sy_r);
          gx_r    <= 33'($signed(wall_rd_r[95:64]))  - 33'($signed(wall_rd_r[31:0]));
          gy_r    <= 33'($signed(wall_rd_r[127:96])) - 33'($signed(wall_rd_r[63:32]));
          mstep_r <= '0;
          state_r <= S_WMUL;
        end

        // four cross products, one multiply per cycle, each difference in the cycle after its second multiply
        S_WMUL: begin
          mstep_r <= mstep_r + 4'd1;
          case (mstep_r)
            4'd1, 4'd3, 4'd5, 4'd7: acc_r <= prod_r;
            4'd2: k1n_r <= acc_dif[PW-1];
            4'd4: k2n_r <= acc_dif[PW-1];
            4'd6: k3_r  <= acc_dif;
            4'd8: begin
              k4_r    <= acc_dif;
              state_r <= S_WTEST;
            end
            default: ;
          endcase
        end

        S_WTEST: begin
          if (k1n_r || k2n_r || k3_r[PW-1] || k4_r[PW-1] || (k4_r == '0)) begin
            widx_r  <= widx_r + WALL_CW'(1);
            state_r <= S_WRD;
          end else begin
            dnum_r  <= {k3_r[66:0], 30'b0};
            drem_r  <= '0;
            dq_r    <= '0;
            dsat_r  <= 1'b0;
            cnt_r   <= '0;
            state_r <= S_WDIV;
          end
        end

        // one quotient bit per cycle; bits above 64 only mark saturation
        S_WDIV: begin
          drem_r <= div_take ? (rem_sh - $unsigned(k4_r)) : rem_sh;
          dq_r   <= {dq_r[62:0], div_take};
          dsat_r <= dsat_r | dq_r[63];
          dnum_r <= {dnum_r[DIV_STEPS-2:0], 1'b0};
          cnt_r  <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) begin
            state_r <= S_WCMP;
          end
        end

        // only a strictly nearer wall needs its normal angle
        S_WCMP: begin
          if (!wok_r || (wd_cand < wd_r)) begin
            wok_r      <= 1'b1;
            wd_r       <= wd_cand;
            ret_circ_r <= 1'b0;
            cx_r       <= 40'(gy_r);
            cy_r       <= -40'(gx_r);
            state_r    <= S_ANORM;
          end else begin
            widx_r  <= widx_r + WALL_CW'(1);
            state_r <= S_WRD;
          end
        end

        S_CRD: begin
          state_r <= circs_done ? S_DONE : S_CDIFF;
        end

        S_CDIFF: begin
          wx_r    <= 33'($signed(circ_rd_r[31:0]))  - 33'(sx_r);
          wy_r    <= 33'($signed(circ_rd_r[63:32])) - 33'(sy_r);
          rad_r   <= $signed(circ_rd_r[95:64]);
          mstep_r <= '0;
          state_r <= S_CMUL;
        end

        // dot, cross and discriminant
        S_CMUL: begin
          mstep_r <= mstep_r + 4'd1;
          case (mstep_r)
            4'd1, 4'd3, 4'd5: acc_r <= prod_r;
            4'd2: along_r  <= 36'(acc_sum >>> 30);
            4'd4: across_r <= 36'(acc_dif >>> 30);
            4'd6: begin
              disc_r  <= acc_dif;
              state_r <= S_CTEST;
            end
            default: ;
          endcase
        end

        S_CTEST: begin
          if (disc_r[PW-1]) begin
            cidx_r  <= cidx_r + CIRC_CW'(1);
            state_r <= S_CRD;
          end else begin
            sq_n_r    <= disc_r[63:0];
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            cnt_r     <= '0;
            state_r   <= S_CSQRT;
          end
        end

        S_CSQRT: begin
          sq_rem_r  <= sq_take ? 34'(sq_r2 - sq_trial) : 34'(sq_r2);
          sq_root_r <= {sq_root_r[30:0], sq_take};
          sq_n_r    <= {sq_n_r[61:0], 2'b00};
          cnt_r     <= cnt_r + 7'd1;
          if (cnt_r == 7'd31) begin
            state_r <= S_CT;
          end
        end

        S_CT: begin
          if (t_ok && (!cok_r || (t_u < cd_r))) begin
            cok_r      <= 1'b1;
            cd_r       <= t_u;
            t_r        <= 36'(t_sel);
            ret_circ_r <= 1'b1;
            mstep_r    <= '0;
            state_r    <= S_CVEC;
          end else begin
            cidx_r  <= cidx_r + CIRC_CW'(1);
            state_r <= S_CRD;
          end
        end

        // normal vector: centre offset minus t along the ray
        S_CVEC: begin
          mstep_r <= mstep_r + 4'd1;
          case (mstep_r)
            4'd1: cx_r <= 40'(wx_r) - 40'(prod_r >>> 30);
            4'd2: begin
              cy_r    <= 40'(wy_r) - 40'(prod_r >>> 30);
              state_r <= S_ANORM;
            end
            default: ;
          endcase
        end

        S_ANORM: begin
          if ((cx_r == '0) && (cy_r == '0)) begin
            cz_r    <= '0;
            state_r <= S_AFIN;
          end else begin
            state_r <= S_ADN;
          end
        end

        // scale down below 2^31, one bit per cycle
        S_ADN: begin
          if (big_m >= 40'h0080000000) begin
            cx_r <= cx_r >>> 1;
            cy_r <= cy_r >>> 1;
          end else begin
            state_r <= S_AUP;
          end
        end

        // scale up to at least 2^30, then fold into the right half-plane
        S_AUP: begin
          if (big_m < 40'h0040000000) begin
            cx_r <= cx_r <<< 1;
            cy_r <= cy_r <<< 1;
          end else begin
            if (cx_r[39]) begin
              cx_r <= -cx_r;
              cy_r <= -cy_r;
              cz_r <= 32'h80000000;
            end else begin
              cz_r <= '0;
            end
            cnt_r   <= '0;
            state_r <= S_AROT;
          end
        end

        S_AFIN: begin
          if (ret_circ_r) begin
            ca_r    <= cz_r;
            cidx_r  <= cidx_r + CIRC_CW'(1);
            state_r <= S_CRD;
          end else begin
            wa_r    <= cz_r;
            widx_r  <= widx_r + WALL_CW'(1);
            state_r <= S_WRD;
          end
        end

        S_DONE: begin
          out_valid_r             <= 1'b1;
          out_data_r.hit          <= fin_hit;
          out_data_r.range        <= !fin_hit ? '1
                                     : ((fin_d[63:32] != '0) ? '1 : fin_d[31:0]);
          out_data_r.normal_angle <= fin_hit ? norm_tmp[31:ANGLE_SH] : '0;
          state_r                 <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a result strobe only follows the final state of a query
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DONE))
    else $error("result strobe without a finished query");

  // an accepted query makes the block busy on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type == REQ_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // a miss reports the saturated range and a zero angle
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.hit) |-> ((out_data.range == '1) && (out_data.normal_angle == '0)))
    else $error("miss result with range or angle set");

  // write requests never occupy the sequencer
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_data.req_type == REQ_WALL) || (in_data.req_type == REQ_CIRCLE)))
    |=> !busy)
    else $error("table write made the block busy");

endmodule

FILE: sim/ray_wall_circle_distance_tb.sv
// ray_wall_circle_distance_tb: self-checking bench for the ray range finder
// predicts each query result in exact integer math and checks it; needs rwcd_pkg
// and ray_wall_circle_distance
module ray_wall_circle_distance_tb;
  import rwcd_pkg::*;

  typedef logic signed [127:0] s128;

  // request kind with no meaning, must be swallowed without a result
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam longint GAIN = 64'sd652032874;
  localparam int     UNIT = 1 << 16;
  localparam longint ATAN_TURNS [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_req_t    in_data = '0;
  logic       out_valid;
  out_res_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;

  ray_wall_circle_distance u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the wall and circle tables, plus which slots were ever loaded
  int         wall_ax [MAX_WALLS];
  int         wall_ay [MAX_WALLS];
  int         wall_bx [MAX_WALLS];
  int         wall_by [MAX_WALLS];
  bit         wall_seen [MAX_WALLS];
  int         circ_x [MAX_CIRCLES];
  int         circ_y [MAX_CIRCLES];
  int         circ_r [MAX_CIRCLES];
  bit         circ_seen [MAX_CIRCLES];
  logic [6:0] wall_cnt = '0;
  logic [5:0] circ_cnt = '0;

  out_res_t   pending_ranges [$];
  int         err_count = 0;
  int         idle_pct = 0;

  // ---------------------------------------------------------------------
  // range predictor
  // ---------------------------------------------------------------------

  function automatic s128 wide(input longint v);
    return v;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // unit heading vector in Q2.30, rotation-mode cordic on the first quadrant
  function automatic void heading_vec(input logic [31:0] th, output longint ex,
                                      output longint ey);
    longint x, y, z, nx;
    x = GAIN;
    y = 0;
    z = longint'(th[29:0]);
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i];
      end
      x = nx;
    end
    // quadrant swap
    case (th[31:30])
      2'd0: begin ex = x;  ey = y;  end
      2'd1: begin ex = -y; ey = x;  end
      2'd2: begin ex = -x; ey = -y; end
      default: begin ex = y; ey = -x; end
    endcase
  endfunction

  // angle of a vector in turns of 2^-32, vectoring cordic after normalizing
  function automatic logic [31:0] vec_turn(input longint x, input longint y);
    logic [31:0]     z;
    longint          nx;
    longint unsigned big;
    z = '0;
    if (x == 0 && y == 0) return '0;
    big = (mag(x) > mag(y)) ? mag(x) : mag(y);
    while (big >= 64'd2147483648) begin
      x = x >>> 1;
      y = y >>> 1;
      big = (mag(x) > mag(y)) ? mag(x) : mag(y);
    end
    while (big < 64'd1073741824) begin
      x = x * 2;
      y = y * 2;
      big = big * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 30; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i][31:0];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i][31:0];
      end
      x = nx;
    end
    return z;
  endfunction

  // wall crossing: all determinant tests non-negative, strictly facing
  function automatic bit wall_cross(input int j, input longint sx, input longint sy,
                                    input longint ex, input longint ey,
                                    output logic [63:0] hit_d, output logic [31:0] ang);
    longint rax, ray, rbx, rby, gx, gy;
    s128    k1, k2, k3, k4, quo;
    rax = longint'(wall_ax[j]) - sx;
    ray = longint'(wall_ay[j]) - sy;
    rbx = longint'(wall_bx[j]) - sx;
    rby = longint'(wall_by[j]) - sy;
    gx  = longint'(wall_bx[j]) - longint'(wall_ax[j]);
    gy  = longint'(wall_by[j]) - longint'(wall_ay[j]);
    k1 = wide(rax) * wide(ey) - wide(ex) * wide(ray);
    k2 = wide(ex) * wide(rby) - wide(rbx) * wide(ey);
    k3 = wide(rax) * wide(gy) - wide(gx) * wide(ray);
    k4 = wide(ex) * wide(gy) - wide(gx) * wide(ey);
    hit_d = '0;
    ang   = '0;
    if (k1 < 0 || k2 < 0 || k3 < 0 || k4 <= 0) return 1'b0;
    quo = (k3 <<< 30) / k4;
    // distance saturates at 64 bits before any comparison
    hit_d = (quo[127:64] != '0) ? '1 : quo[63:0];
    ang   = vec_turn(gy, -gx);
    return 1'b1;
  endfunction

  // circle crossing at the nearest intersection strictly ahead
  function automatic bit circle_cross(input int j, input longint sx, input longint sy,
                                      input longint ex, input longint ey,
                                      output logic [63:0] hit_d, output logic [31:0] ang);
    longint       wx, wy, rad, along, across, root, t, tx, ty;
    s128          acc, disc;
    logic [127:0] n, cand, sq;
    wx  = longint'(circ_x[j]) - sx;
    wy  = longint'(circ_y[j]) - sy;
    rad = longint'(circ_r[j]);
    acc = (wide(wx) * wide(ex) + wide(wy) * wide(ey)) >>> 30;
    along = longint'(acc[63:0]);
    acc = (wide(wx) * wide(ey) - wide(wy) * wide(ex)) >>> 30;
    across = longint'(acc[63:0]);
    disc = wide(rad) * wide(rad) - wide(across) * wide(across);
    hit_d = '0;
    ang   = '0;
    if (disc < 0) return 1'b0;
    n = disc;
    sq = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = sq | (128'd1 << b);
      if (n >= cand * cand) sq = cand;
    end
    root = longint'(sq[63:0]);
    if (along - root > 0) t = along - root;
    else if (along + root > 0) t = along + root;
    else return 1'b0;
    hit_d = t;
    acc = (wide(t) * wide(ex)) >>> 30;
    tx  = longint'(acc[63:0]);
    acc = (wide(t) * wide(ey)) >>> 30;
    ty  = longint'(acc[63:0]);
    ang = vec_turn(wx - tx, wy - ty);
    return 1'b1;
  endfunction

  function automatic out_res_t predict_range(input in_req_t r);
    out_res_t    res;
    logic [31:0] theta, a, wa, ca, rel;
    logic [63:0] d, wd, cd;
    bit          wok, cok;
    longint      sx, sy, ex, ey;
    int          nw, nc;
    wok = 1'b0;
    cok = 1'b0;
    wd = '0;
    cd = '0;
    wa = '0;
    ca = '0;
    theta = {r.heading, {ANGLE_SH{1'b0}}};
    sx = longint'(r.px);
    sy = longint'(r.py);
    heading_vec(theta, ex, ey);
    nw = (wall_cnt > MAX_WALLS) ? MAX_WALLS : int'(wall_cnt);
    nc = (circ_cnt > MAX_CIRCLES) ? MAX_CIRCLES : int'(circ_cnt);
    // first slot wins a tie inside each table
    for (int j = 0; j < nw; j++)
      if (wall_cross(j, sx, sy, ex, ey, d, a) && (!wok || d < wd)) begin
        wok = 1'b1;
        wd  = d;
        wa  = a;
      end
    for (int j = 0; j < nc; j++)
      if (circle_cross(j, sx, sy, ex, ey, d, a) && (!cok || d < cd)) begin
        cok = 1'b1;
        cd  = d;
        ca  = a;
      end
    res = '0;
    // a wall only beats a circle when strictly nearer
    if (wok && (!cok || wd < cd)) begin
      d = wd;
      a = wa;
    end else if (cok) begin
      d = cd;
      a = ca;
    end else begin
      res.range = '1;
      return res;
    end
    res.range = (d[63:32] != '0) ? 32'hFFFF_FFFF : d[31:0];
    rel = a - theta + (32'd1 << (ANGLE_SH - 1));
    res.normal_angle = rel[31:ANGLE_SH];
    res.hit = 1'b1;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------

  // update the shadow tables, or queue the expected range of a query
  task automatic apply_request(input in_req_t r);
    case (r.req_type)
      REQ_WALL: begin
        wall_ax[r.slot] = r.px;
        wall_ay[r.slot] = r.py;
        wall_bx[r.slot] = r.qx;
        wall_by[r.slot] = r.qy;
        wall_seen[r.slot] = 1'b1;
      end
      REQ_CIRCLE: begin
        // slots past the circle table are dropped
        if (r.slot < MAX_CIRCLES) begin
          circ_x[r.slot[CIRC_AW-1:0]] = r.px;
          circ_y[r.slot[CIRC_AW-1:0]] = r.py;
          circ_r[r.slot[CIRC_AW-1:0]] = r.qx;
          circ_seen[r.slot[CIRC_AW-1:0]] = 1'b1;
        end
      end
      REQ_QUERY: pending_ranges = {pending_ranges, predict_range(r)};
      default: ;
    endcase
  endtask

  // a query drops start at its accepting edge and waits out busy; after a write
  // start stays high until an idle gap in the next call or a drain lowers it
  task automatic issue(input in_req_t r);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= r;
    @(posedge clk);
    apply_request(r);
    if (r.req_type == REQ_QUERY) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
    end
  endtask

  // hold off until every queued range has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_ranges.size() != 0);
  endtask

  task automatic set_count(input logic idx, input logic [6:0] v);
    drain();
    // writes give no result, so wait out the sequencer too
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WALL_COUNT) wall_cnt = v;
    else circ_cnt = v[5:0];
  endtask

  // ---------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------

  function automatic int coord(input int span);
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, 2 * span)) - span;
    return $urandom;
  endfunction

  function automatic in_req_t mk(input logic [1:0] kind, input int slot, input int px,
                                 input int py, input int qx, input int qy,
                                 input logic [15:0] hd);
    in_req_t r;
    r.req_type = kind;
    r.slot     = slot[5:0];
    r.px       = px;
    r.py       = py;
    r.qx       = qx;
    r.qy       = qy;
    r.heading  = hd;
    return r;
  endfunction

  function automatic in_req_t rand_wall(input int slot);
    return mk(REQ_WALL, slot, coord(100 * UNIT), coord(100 * UNIT), coord(100 * UNIT),
              coord(100 * UNIT), $urandom);
  endfunction

  function automatic in_req_t rand_circle(input int slot);
    int rad;
    case ($urandom_range(0, 9))
      0: rad = -int'($urandom_range(1, 30 * UNIT));
      1: rad = $urandom;
      default: rad = $urandom_range(1, 30 * UNIT);
    endcase
    return mk(REQ_CIRCLE, slot, coord(100 * UNIT), coord(100 * UNIT), rad, $urandom,
              $urandom);
  endfunction

  function automatic in_req_t rand_query();
    return mk(REQ_QUERY, $urandom, coord(20 * UNIT), coord(20 * UNIT), $urandom,
              $urandom, $urandom);
  endfunction

  function automatic int wall_prefix();
    int n;
    n = 0;
    while (n < MAX_WALLS && wall_seen[n]) n++;
    return n;
  endfunction

  function automatic int circle_prefix();
    int n;
    n = 0;
    while (n < MAX_CIRCLES && circ_seen[n]) n++;
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n && out_valid) begin
      if (pending_ranges.size() == 0) begin
        report_mismatch("unexpected result, range", out_data.range, '0);
      end else begin
        want = pending_ranges.pop_front();
        if (out_data.range !== want.range)
          report_mismatch("range", out_data.range, want.range);
        if (out_data.normal_angle !== want.normal_angle)
          report_mismatch("normal_angle", 32'(out_data.normal_angle),
                          32'(want.normal_angle));
        if (out_data.hit !== want.hit)
          report_mismatch("hit", 32'(out_data.hit), 32'(want.hit));
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // empty tables: every query misses; the unused request kind is swallowed
  task automatic test_empty_tables();
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h0000));
    issue(mk(REQ_NONE, 63, -1, -1, -1, -1, 16'hFFFF));
    issue(mk(REQ_QUERY, 63, 32'h8000_0000, 32'h7FFF_FFFF, -1, -1, 16'hFFFF));
  endtask

  // hand-placed walls: facing, duplicate tie, parallel, back side, far extremes
  task automatic test_walls();
    issue(mk(REQ_WALL, 0, 10 * UNIT, -10 * UNIT, 10 * UNIT, 10 * UNIT, 0));
    issue(mk(REQ_WALL, 1, 10 * UNIT, -10 * UNIT, 10 * UNIT, 10 * UNIT, 0));
    issue(mk(REQ_WALL, 2, 0, 5 * UNIT, 20 * UNIT, 5 * UNIT, 0));
    issue(mk(REQ_WALL, 3, -8 * UNIT, 10 * UNIT, -8 * UNIT, -10 * UNIT, 0));
    // walls at the coordinate extremes, both windings, for the saturated range
    issue(mk(REQ_WALL, 4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    issue(mk(REQ_WALL, 5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    set_count(REG_WALL_COUNT, 7'd6);
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h0000));
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h8000));
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h4000));
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'hC000));
    issue(mk(REQ_QUERY, 0, 32'h8000_0000, 0, 0, 0, 16'h0000));
    issue(mk(REQ_QUERY, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h2000));
  endtask

  // circles: ahead, sensor inside, negative radius, dropped slot, huge radius
  task automatic test_circles();
    issue(mk(REQ_CIRCLE, 0, 20 * UNIT, 0, 5 * UNIT, 0, 0));
    issue(mk(REQ_CIRCLE, 1, 0, 0, 3 * UNIT, 0, 0));
    issue(mk(REQ_CIRCLE, 2, -20 * UNIT, 0, -5 * UNIT, 0, 0));
    issue(mk(REQ_CIRCLE, 40, 0, 0, 1 * UNIT, 0, 0));
    issue(mk(REQ_CIRCLE, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    set_count(REG_CIRCLE_COUNT, 7'd4);
    set_count(REG_WALL_COUNT, 7'd0);
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h0000));
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h8000));
    issue(mk(REQ_QUERY, 0, 30 * UNIT, 0, 0, 0, 16'h8000));
    issue(mk(REQ_QUERY, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 16'h1FFF));
    // walls and circles racing for the nearest hit
    set_count(REG_WALL_COUNT, 7'd4);
    issue(mk(REQ_QUERY, 0, 5 * UNIT, 0, 0, 0, 16'h0000));
    issue(mk(REQ_QUERY, 0, 0, 0, 0, 0, 16'h0001));
  endtask

  // random mix of table loads and queries at one sender idling rate
  task automatic test_random_mix(input int pct, input int n_items);
    int pick;
    idle_pct = pct;
    set_count(REG_WALL_COUNT, 7'($urandom_range(0, wall_prefix())));
    set_count(REG_CIRCLE_COUNT, 7'($urandom_range(0, circle_prefix())));
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) issue(rand_wall($urandom_range(0, 15)));
      else if (pick < 30) issue(rand_wall($urandom_range(0, 63)));
      else if (pick < 45) issue(rand_circle($urandom_range(0, 11)));
      else if (pick < 48) issue(rand_circle($urandom_range(0, 63)));
      else if (pick < 50) issue(mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
      else issue(rand_query());
      if ($urandom_range(0, 99) < 4) drain();
    end
  endtask

  // fully loaded tables, counts above the table size and exactly at it
  task automatic test_full_tables();
    idle_pct = 0;
    for (int j = 0; j < MAX_WALLS; j++) issue(rand_wall(j));
    for (int j = 0; j < MAX_CIRCLES; j++) issue(rand_circle(j));
    set_count(REG_WALL_COUNT, 7'h7F);
    set_count(REG_CIRCLE_COUNT, 7'h7F);
    repeat (3) issue(rand_query());
    set_count(REG_WALL_COUNT, 7'd64);
    set_count(REG_CIRCLE_COUNT, 7'd32);
    repeat (3) issue(rand_query());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_tables();
    test_walls();
    test_circles();
    // random counts only reach slots that were loaded above
    test_random_mix(0, 8);
    test_random_mix(76, 8);
    test_random_mix(14, 8);
    test_random_mix(0, 8);
    test_full_tables();
    drain();
    for (int k = 0; k < 20000 && busy; k++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0 && pending_ranges.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #160000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rwcd_pkg.sv
rtl/ray_wall_circle_distance.sv
sim/ray_wall_circle_distance_tb.sv
